FILE: design/udpdmx_pkg.sv
// Shared types and constants for the UDP socket demultiplexing table.
package udpdmx_pkg;

   localparam int TABLE_DEPTH_DEF = 16;

   localparam logic [31:0] NETMASK_RESET = 32'hFFFF_FF00;

   localparam logic [1:0] OPC_LOOKUP = 2'd0;
   localparam logic [1:0] OPC_ADD    = 2'd1;
   localparam logic [1:0] OPC_REMOVE = 2'd2;

   localparam logic [2:0] ST_HIT     = 3'd0;
   localparam logic [2:0] ST_MISS    = 3'd1;
   localparam logic [2:0] ST_ADDED   = 3'd2;
   localparam logic [2:0] ST_PRESENT = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;
   localparam logic [2:0] ST_REMOVED = 3'd5;
   localparam logic [2:0] ST_ABSENT  = 3'd6;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  socket_handle;
      logic [31:0] bind_local_ip;
      logic [15:0] bind_local_port;
      logic [31:0] bind_remote_ip;
      logic [15:0] bind_remote_port;
      logic [31:0] pkt_src_ip;
      logic [31:0] pkt_dst_ip;
      logic [15:0] pkt_src_port;
      logic [15:0] pkt_dst_port;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] found_handle;
      logic       exact_hit;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  handle;
      logic [31:0] lcl_addr;
      logic [15:0] lcl_port;
      logic [31:0] rmt_addr;
      logic [15:0] rmt_port;
   } slot_type;

   typedef struct packed {
      logic       valid;
      req_type    req;
      logic       added;
      logic       present;
      logic       removing;
      logic       exact_hit;
      logic [7:0] exact_handle;
      logic       loose_hit;
      logic [7:0] loose_handle;
   } token_type;

endpackage

FILE: design/udpdmx_cell.sv
// One table slot that updates itself and its passing word, then hands the word on.
module udpdmx_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           netmask,
   input  udpdmx_pkg::token_type tok_in,
   input  udpdmx_pkg::slot_type  nb_slot,
   output udpdmx_pkg::token_type tok_out,
   output udpdmx_pkg::slot_type  slot_out
);
   import udpdmx_pkg::*;

   slot_type  slot_ff, slot_in;
   token_type tok_ff, tok_pass_in;
   logic [31:0] host;
   logic        rip_ok, lip_ok, exact_m, loose_m, own;

   always_comb begin
      host    = ~netmask;
      rip_ok  = (slot_ff.rmt_addr == 32'd0) || (slot_ff.rmt_addr == tok_in.req.pkt_src_ip);
      lip_ok  = (slot_ff.lcl_addr == 32'd0) || (slot_ff.lcl_addr == tok_in.req.pkt_dst_ip);
      loose_m = slot_ff.valid && (slot_ff.lcl_port == tok_in.req.pkt_dst_port)
                && rip_ok && lip_ok;
      exact_m = slot_ff.valid && (slot_ff.lcl_port == tok_in.req.pkt_dst_port)
                && (slot_ff.rmt_port == tok_in.req.pkt_src_port) && lip_ok
                && (rip_ok || ((slot_ff.rmt_addr & host) == host));
      own     = slot_ff.valid && (slot_ff.handle == tok_in.req.socket_handle);

      slot_in     = slot_ff;
      tok_pass_in = tok_in;
      if (tok_in.valid) begin
         unique case (tok_in.req.opcode)
            OPC_LOOKUP: begin
               if (exact_m && !tok_in.exact_hit) begin
                  tok_pass_in.exact_hit    = 1'b1;
                  tok_pass_in.exact_handle = slot_ff.handle;
               end
               if (loose_m && !tok_in.loose_hit) begin
                  tok_pass_in.loose_hit    = 1'b1;
                  tok_pass_in.loose_handle = slot_ff.handle;
               end
            end
            OPC_ADD: begin
               if (own) begin
                  tok_pass_in.present = 1'b1;
               end else if (!slot_ff.valid && !tok_in.added && !tok_in.present) begin
                  slot_in.valid       = 1'b1;
                  slot_in.handle      = tok_in.req.socket_handle;
                  slot_in.lcl_addr    = tok_in.req.bind_local_ip;
                  slot_in.lcl_port    = tok_in.req.bind_local_port;
                  slot_in.rmt_addr    = tok_in.req.bind_remote_ip;
                  slot_in.rmt_port    = tok_in.req.bind_remote_port;
                  tok_pass_in.added   = 1'b1;
               end
            end
            OPC_REMOVE: begin
               if (tok_in.removing || own) begin
                  slot_in              = nb_slot;
                  tok_pass_in.removing = 1'b1;
               end
            end
            default: begin
               slot_in = slot_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         tok_ff  <= '0;
      end else begin
         slot_ff <= slot_in;
         tok_ff  <= tok_pass_in;
      end
   end

   assign tok_out  = tok_ff;
   assign slot_out = slot_ff;

endmodule

FILE: design/udp_socket_demux_table.sv
// Top level of the UDP socket demultiplexing table: a chain of slot cells.
// A word walks the chain one cell per cycle; its response is registered in the output
// queue when the word leaves the last cell, and the next word is taken only after that,
// so only one word is in the cell chain at a time.
// A two-entry output queue lets a word be accepted while a response waits.
// Synchronous reset empties the table and sets the netmask to 255.255.255.0.
module udp_socket_demux_table #(
   parameter int TABLE_DEPTH = udpdmx_pkg::TABLE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  udpdmx_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output udpdmx_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic [31:0]         csr_wdata
);
   import udpdmx_pkg::*;

   logic [31:0] netmask_ff;
   logic        busy_ff, busy_in;
   token_type   tok_ff, tok_in;
   token_type   tok_chain [TABLE_DEPTH+1];
   slot_type    slots [TABLE_DEPTH];
   rsp_type     result;
   rsp_type     head_ff, head_in, spare_ff, spare_in;
   logic        head_valid_ff, head_valid_in, spare_valid_ff, spare_valid_in;
   logic        accept, push, pop;

   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff && !spare_valid_ff;
   assign push      = tok_chain[TABLE_DEPTH].valid;
   assign pop       = head_valid_ff && rsp_ready;
   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;

   always_comb begin
      tok_in          = '0;
      tok_in.valid    = accept;
      tok_in.req      = req_data;
      busy_in         = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (push) begin
         busy_in = 1'b0;
      end
   end

   assign tok_chain[0] = tok_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      slot_type nb;
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign nb = '0;
      end else begin : g_mid
         assign nb = slots[i+1];
      end
      udpdmx_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .netmask  (netmask_ff),
         .tok_in   (tok_chain[i]),
         .nb_slot  (nb),
         .tok_out  (tok_chain[i+1]),
         .slot_out (slots[i])
      );
   end

   always_comb begin
      token_type t;
      t      = tok_chain[TABLE_DEPTH];
      result = '0;
      result.status = ST_MISS;
      unique case (t.req.opcode)
         OPC_LOOKUP: begin
            priority if (t.exact_hit) begin
               result.status       = ST_HIT;
               result.found_handle = t.exact_handle;
               result.exact_hit    = 1'b1;
            end else if (t.loose_hit) begin
               result.status       = ST_HIT;
               result.found_handle = t.loose_handle;
            end else begin
               result.status = ST_MISS;
            end
         end
         OPC_ADD: begin
            priority if (t.present) begin
               result.status = ST_PRESENT;
            end else if (t.added) begin
               result.status = ST_ADDED;
            end else begin
               result.status = ST_FULL;
            end
         end
         OPC_REMOVE: begin
            result.status = t.removing ? ST_REMOVED : ST_ABSENT;
         end
         default: begin
            result.status = ST_MISS;
         end
      endcase
   end

   always_comb begin
      head_in        = head_ff;
      head_valid_in  = head_valid_ff;
      spare_in       = spare_ff;
      spare_valid_in = spare_valid_ff;
      if (pop) begin
         if (spare_valid_ff) begin
            head_in        = spare_ff;
            spare_valid_in = push;
            spare_in       = result;
         end else begin
            head_valid_in = push;
            head_in       = result;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = result;
            head_valid_in = 1'b1;
         end else begin
            spare_in       = result;
            spare_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
      if (reset) begin
         netmask_ff     <= NETMASK_RESET;
         busy_ff        <= 1'b0;
         tok_ff         <= '0;
         head_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            netmask_ff <= csr_wdata;
         end
         busy_ff        <= busy_in;
         tok_ff         <= tok_in;
         head_valid_ff  <= head_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

endmodule

FILE: tb/sv/socket_table_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the socket table's replies.
package socket_table_tb_pkg;

   import udpdmx_pkg::*;

   localparam logic [1:0] OPC_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0]  handle;
      logic [31:0] lcl_addr;
      logic [15:0] lcl_port;
      logic [31:0] rmt_addr;
      logic [15:0] rmt_port;
   } socket_type;

   class socket_table_scoreboard;
      logic [31:0] netmask;
      socket_type  sockets[$];
      rsp_type     expected_replies[$];
      int unsigned failures;
      int unsigned replies_seen;

      function new();
         netmask = NETMASK_RESET;
      endfunction

      function int index_of(logic [7:0] handle);
         for (int i = 0; i < sockets.size(); i++) begin
            if (sockets[i].handle == handle) begin
               return i;
            end
         end
         return -1;
      endfunction

      // Applies one word to the table and returns the reply it must produce.
      function rsp_type classify(req_type w);
         rsp_type    r;
         socket_type s;
         logic [31:0] host;
         int          hit;
         r.status = ST_MISS;
         r.found_handle = 8'h00;
         r.exact_hit = 1'b0;
         host = ~netmask;
         hit = -1;
         case (w.opcode)
            OPC_LOOKUP: begin
               for (int i = 0; i < sockets.size(); i++) begin
                  s = sockets[i];
                  if (s.rmt_port == w.pkt_src_port && s.lcl_port == w.pkt_dst_port &&
                      (s.rmt_addr == 32'hFFFF_FFFF || (s.rmt_addr & host) == host ||
                       s.rmt_addr == 32'h0 || s.rmt_addr == w.pkt_src_ip) &&
                      (s.lcl_addr == 32'h0 || s.lcl_addr == w.pkt_dst_ip)) begin
                     hit = i;
                     r.exact_hit = 1'b1;
                     break;
                  end
               end
               if (hit < 0) begin
                  for (int i = 0; i < sockets.size(); i++) begin
                     s = sockets[i];
                     if (s.lcl_port == w.pkt_dst_port &&
                         (s.rmt_addr == 32'h0 || s.rmt_addr == w.pkt_src_ip) &&
                         (s.lcl_addr == 32'h0 || s.lcl_addr == w.pkt_dst_ip)) begin
                        hit = i;
                        break;
                     end
                  end
               end
               if (hit >= 0) begin
                  r.status = ST_HIT;
                  r.found_handle = sockets[hit].handle;
               end
            end
            OPC_ADD: begin
               if (index_of(w.socket_handle) >= 0) begin
                  r.status = ST_PRESENT;
               end else if (sockets.size() >= TABLE_DEPTH_DEF) begin
                  r.status = ST_FULL;
               end else begin
                  s.handle = w.socket_handle;
                  s.lcl_addr = w.bind_local_ip;
                  s.lcl_port = w.bind_local_port;
                  s.rmt_addr = w.bind_remote_ip;
                  s.rmt_port = w.bind_remote_port;
                  sockets.push_back(s);
                  r.status = ST_ADDED;
               end
            end
            OPC_REMOVE: begin
               hit = index_of(w.socket_handle);
               if (hit < 0) begin
                  r.status = ST_ABSENT;
               end else begin
                  sockets.delete(hit);
                  r.status = ST_REMOVED;
               end
            end
            default: begin
            end
         endcase
         return r;
      endfunction

      function void note_request(req_type w);
         expected_replies.push_back(classify(w));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         replies_seen++;
         if (expected_replies.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("reply %0d: none expected, got status %0d handle 0x%02h exact %0b",
                        replies_seen, got.status, got.found_handle, got.exact_hit);
            end
            return;
         end
         want = expected_replies.pop_front();
         if (got.status !== want.status || got.found_handle !== want.found_handle ||
             got.exact_hit !== want.exact_hit) begin
            failures++;
            if (failures <= 10) begin
               $display("reply %0d: expected status %0d handle 0x%02h exact %0b,",
                        replies_seen, want.status, want.found_handle, want.exact_hit);
               $display("   got status %0d handle 0x%02h exact %0b",
                        got.status, got.found_handle, got.exact_hit);
            end
         end
      endfunction
   endclass

endpackage

FILE: tb/sv/testbench.sv
// Top-level testbench that drives the socket table and checks every reply.
module testbench;

   import udpdmx_pkg::*;
   import socket_table_tb_pkg::*;

   localparam int HOLD_CYCLES = 200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [31:0] csr_wdata = 32'h0;

   logic calm = 1'b0;
   logic hold_asked = 1'b0;

   socket_table_scoreboard board;
   socket_table_scoreboard shadow;

   udp_socket_demux_table uut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .csr_we,
      .csr_wdata
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         board.note_request(req_data);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response(rsp_data);
      end
   end

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_asked) begin
            hold_asked = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 8);
      end
   end

   initial begin : watchdog
      #(12 * 400000);
      $display("udp_socket_demux_table: mismatch");
      $finish;
   end

   function automatic req_type noise_word();
      req_type w;
      w.opcode = 2'($urandom);
      w.socket_handle = 8'($urandom);
      w.bind_local_ip = $urandom;
      w.bind_local_port = 16'($urandom);
      w.bind_remote_ip = $urandom;
      w.bind_remote_port = 16'($urandom);
      w.pkt_src_ip = $urandom;
      w.pkt_dst_ip = $urandom;
      w.pkt_src_port = 16'($urandom);
      w.pkt_dst_port = 16'($urandom);
      return w;
   endfunction

   function automatic logic [31:0] pool_addr();
      return 32'h0A00_0000 | ($urandom_range(0, 3) << 8) | $urandom_range(1, 6);
   endfunction

   function automatic logic [15:0] pool_port();
      return 16'(1000 + $urandom_range(0, 3));
   endfunction

   function automatic logic [7:0] pool_handle();
      if ($urandom_range(0, 6) == 0) begin
         return 8'($urandom);
      end
      return 8'($urandom_range(0, 23));
   endfunction

   function automatic req_type add_word(logic [7:0] h, logic [31:0] lip, logic [15:0] lport,
                                        logic [31:0] rip, logic [15:0] rport);
      req_type w;
      w = noise_word();
      w.opcode = OPC_ADD;
      w.socket_handle = h;
      w.bind_local_ip = lip;
      w.bind_local_port = lport;
      w.bind_remote_ip = rip;
      w.bind_remote_port = rport;
      return w;
   endfunction

   function automatic req_type lookup_word(logic [31:0] sip, logic [31:0] dip,
                                           logic [15:0] sport, logic [15:0] dport);
      req_type w;
      w = noise_word();
      w.opcode = OPC_LOOKUP;
      w.pkt_src_ip = sip;
      w.pkt_dst_ip = dip;
      w.pkt_src_port = sport;
      w.pkt_dst_port = dport;
      return w;
   endfunction

   function automatic req_type remove_word(logic [7:0] h);
      req_type w;
      w = noise_word();
      w.opcode = OPC_REMOVE;
      w.socket_handle = h;
      return w;
   endfunction

   // Mostly well-formed adds, removes of bound handles and lookups aimed at bound sockets.
   function automatic req_type random_word(int unsigned add_weight);
      req_type     w;
      socket_type  s;
      int unsigned roll;
      logic [31:0] host;
      w = noise_word();
      roll = $urandom_range(0, 99);
      host = ~shadow.netmask;
      if (roll < 5) begin
         return w;
      end
      if (roll < 5 + add_weight) begin
         w.opcode = OPC_ADD;
         w.socket_handle = pool_handle();
         case ($urandom_range(0, 3))
            0: w.bind_local_ip = 32'h0;
            1, 2: w.bind_local_ip = pool_addr();
            default: begin
            end
         endcase
         if ($urandom_range(0, 3) != 0) begin
            w.bind_local_port = pool_port();
         end
         case ($urandom_range(0, 5))
            0: w.bind_remote_ip = 32'h0;
            1: w.bind_remote_ip = 32'hFFFF_FFFF;
            2: w.bind_remote_ip = pool_addr() | host;
            3, 4: w.bind_remote_ip = pool_addr();
            default: begin
            end
         endcase
         if ($urandom_range(0, 3) != 0) begin
            w.bind_remote_port = pool_port();
         end
      end else if (roll < 25 + add_weight) begin
         w.opcode = OPC_REMOVE;
         if (shadow.sockets.size() > 0 && $urandom_range(0, 3) != 0) begin
            w.socket_handle = shadow.sockets[$urandom_range(0, shadow.sockets.size() - 1)].handle;
         end else begin
            w.socket_handle = pool_handle();
         end
      end else begin
         w.opcode = OPC_LOOKUP;
         w.pkt_src_ip = pool_addr();
         w.pkt_dst_ip = pool_addr();
         w.pkt_src_port = pool_port();
         w.pkt_dst_port = pool_port();
         if (shadow.sockets.size() > 0 && $urandom_range(0, 4) != 0) begin
            s = shadow.sockets[$urandom_range(0, shadow.sockets.size() - 1)];
            w.pkt_dst_port = s.lcl_port;
            if (s.lcl_addr != 32'h0 && $urandom_range(0, 7) != 0) begin
               w.pkt_dst_ip = s.lcl_addr;
            end
            if (s.rmt_addr != 32'h0 && $urandom_range(0, 7) != 0) begin
               w.pkt_src_ip = s.rmt_addr;
            end
            if ($urandom_range(0, 2) != 0) begin
               w.pkt_src_port = s.rmt_port;
            end
         end
      end
      return w;
   endfunction

   task automatic send_word(input req_type w);
      if (!calm && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      void'(shadow.classify(w));
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   task automatic write_netmask(input logic [31:0] mask);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_replies.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= mask;
      @(posedge clock);
      csr_we <= 1'b0;
      board.netmask = mask;
      shadow.netmask = mask;
   endtask

   task automatic run_directed();
      send_word(lookup_word(32'h0A00_0102, 32'h0A00_0001, 16'd5000, 16'd80));
      send_word(remove_word(8'h00));
      send_word(add_word(8'h00, 32'h0, 16'h0, 32'h0, 16'h0));
      send_word(add_word(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
      send_word(add_word(8'h00, 32'h0A00_0001, 16'd80, 32'h0A00_0102, 16'd5000));
      send_word(add_word(8'h11, 32'h0A00_0001, 16'd80, 32'h0A00_0102, 16'd5000));
      send_word(add_word(8'h22, 32'h0, 16'd80, 32'h0A00_01FF, 16'd5000));
      send_word(lookup_word(32'h0A00_0102, 32'h0A00_0001, 16'd5000, 16'd80));
      send_word(lookup_word(32'h0A00_0103, 32'h0A00_0001, 16'd5000, 16'd80));
      send_word(lookup_word(32'h0A00_0102, 32'h0A00_0001, 16'd5001, 16'd80));
      send_word(lookup_word(32'h0A00_0199, 32'h0A00_0009, 16'd5001, 16'd80));
      send_word(lookup_word(32'h0, 32'h0, 16'h0, 16'h0));
      send_word(lookup_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
      send_word(lookup_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 16'hFFFF));
      begin
         req_type w;
         w = noise_word();
         w.opcode = OPC_UNUSED;
         send_word(w);
      end
      send_word(remove_word(8'hFF));
      send_word(lookup_word(32'h0A00_0102, 32'h0A00_0001, 16'd5000, 16'd80));
      send_word(remove_word(8'h00));
      send_word(remove_word(8'h00));
      send_word(remove_word(8'h11));
      send_word(lookup_word(32'h0A00_0102, 32'h0A00_0001, 16'd5000, 16'd80));
   endtask

   initial begin : stimulus
      logic [31:0] masks [5];
      int unsigned weights [5];
      masks = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'hFFFF_0000, 32'hFFFF_FF00};
      weights = '{45, 20, 35, 15, 35};
      masks[2] = $urandom;
      board = new();
      shadow = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int p = 0; p < 5; p++) begin
         write_netmask(masks[p]);
         calm = (p == 2);
         for (int k = 0; k < 100; k++) begin
            if (p == 1 && k == 20) begin
               hold_asked = 1'b1;
            end
            send_word(random_word(weights[p]));
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_replies.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH_DEF + 4) @(posedge clock);
      if (board.failures == 0 && board.expected_replies.size() == 0) begin
         $display("udp_socket_demux_table: match");
      end else begin
         $display("udp_socket_demux_table: mismatch");
      end
      $finish;
   end

endmodule
